>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; each use expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/jsfe_pkg.sv
// ----------------------------------------------------------------------------
// jsfe_pkg
// Types, constants and pattern tables of the JSON string field extractor.
// ----------------------------------------------------------------------------
package jsfe_pkg;

  // Sizing
  localparam int MAX_CAPACITY = 4096;
  localparam int CNT_W        = $clog2(MAX_CAPACITY);
  localparam int CAPE_W       = CNT_W + 1;
  localparam int CAP_W        = 13;
  localparam int LEN_W        = 12;
  localparam int DATA_W       = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;

  // Matcher row: one cell per pattern character of the longest pattern
  localparam int MATCH_CELLS  = 10;
  localparam int CELL_IDX_W   = $clog2(MATCH_CELLS);

  // Output queue
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  // Characters
  localparam logic [DATA_W-1:0] CH_NUL    = 8'h00;
  localparam logic [DATA_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [DATA_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [DATA_W-1:0] CH_BSLASH = 8'h5C;

  // Result kinds
  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MESSAGE_MODE = 1'b0,
    CFG_OUT_CAPACITY = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_CKEY,
    PH_COLON,
    PH_SPACE,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PAT_ANCHOR,
    PAT_CONTENT,
    PAT_RESPONSE
  } pat_sel_t;

  typedef struct packed {
    logic [DATA_W-1:0] frame_byte;
    logic              frame_end;
  } in_word_t;

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] value_byte;
    logic [1:0]        status;
    logic [LEN_W-1:0]  token_length;
    logic              last_result;
  } out_word_t;

  // Per-cycle control of a matcher row
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } cell_ctl_t;

  // Pattern tables, first character at index 0
  localparam logic [0:MATCH_CELLS-1][DATA_W-1:0] ANCHOR_CHARS   = {"\"message\"", 8'h00};
  localparam logic [0:MATCH_CELLS-1][DATA_W-1:0] CONTENT_CHARS  = {"\"content\"", 8'h00};
  localparam logic [0:MATCH_CELLS-1][DATA_W-1:0] RESPONSE_CHARS = "\"response\"";

  localparam logic [CELL_IDX_W-1:0] ANCHOR_LAST   = CELL_IDX_W'(8);
  localparam logic [CELL_IDX_W-1:0] CONTENT_LAST  = CELL_IDX_W'(8);
  localparam logic [CELL_IDX_W-1:0] RESPONSE_LAST = CELL_IDX_W'(9);

  function automatic logic [DATA_W-1:0] pat_char(pat_sel_t sel, logic [CELL_IDX_W-1:0] idx);
    logic [DATA_W-1:0] ch;
    ch = CH_NUL;
    case (sel)
      PAT_ANCHOR:   ch = ANCHOR_CHARS[idx];
      PAT_CONTENT:  ch = CONTENT_CHARS[idx];
      PAT_RESPONSE: ch = RESPONSE_CHARS[idx];
      default:      ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [CELL_IDX_W-1:0] pat_last(pat_sel_t sel);
    logic [CELL_IDX_W-1:0] idx;
    idx = RESPONSE_LAST;
    case (sel)
      PAT_ANCHOR:   idx = ANCHOR_LAST;
      PAT_CONTENT:  idx = CONTENT_LAST;
      PAT_RESPONSE: idx = RESPONSE_LAST;
      default:      idx = RESPONSE_LAST;
    endcase
    return idx;
  endfunction

  // Space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_ws(logic [DATA_W-1:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

>>> rtl/jsfe_match_cell.sv
// ----------------------------------------------------------------------------
// jsfe_match_cell
// One position of a pattern matcher: holds whether the match stands at this
// position and hands a hit on to the next cell.
// ----------------------------------------------------------------------------
module jsfe_match_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  jsfe_pkg::cell_ctl_t       ctl,
  input  logic                      init_val,
  input  logic                      load_val,
  input  logic                      seed,
  input  logic                      from_left,
  input  logic [jsfe_pkg::DATA_W-1:0] data,
  input  logic [jsfe_pkg::DATA_W-1:0] ch,
  input  logic                      is_last,
  output logic                      act,
  output logic                      fwd,
  output logic                      done
);

  logic hit;

  // Compare the word against this cell's character
  assign hit  = act && (data == ch);
  assign fwd  = hit && !is_last;
  assign done = hit && is_last;

  // Hold, restart, preload or advance the position bit
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      act <= init_val;
    end else if (ctl.load) begin
      act <= load_val;
    end else if (ctl.step) begin
      act <= from_left | seed;
    end
  end

endmodule

>>> rtl/jsfe_matcher.sv
// ----------------------------------------------------------------------------
// jsfe_matcher
// Row of match cells tracking the position within one selectable pattern;
// a mismatch restarts at the start, or just past it on a quote.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsfe_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  jsfe_pkg::cell_ctl_t         ctl,
  input  jsfe_pkg::pat_sel_t          pat_sel,
  input  logic [jsfe_pkg::DATA_W-1:0] data,
  output logic                        match_done
);

  import jsfe_pkg::*;

  logic [MATCH_CELLS-1:0] act;
  logic [MATCH_CELLS-1:0] fwd;
  logic [MATCH_CELLS-1:0] done;
  logic [MATCH_CELLS-1:0] seed;
  logic [MATCH_CELLS-1:0] from_left;
  logic [CELL_IDX_W-1:0]  last_idx;
  logic                   any_hit;
  logic                   quote;

  assign last_idx   = pat_last(pat_sel);
  assign any_hit    = |(fwd | done);
  assign quote      = (data == CH_QUOTE);
  assign match_done = |done;

  // Build the row and its fallback inputs
  for (genvar i = 0; i < MATCH_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign from_left[i] = 1'b0;
      assign seed[i]      = (!any_hit && !quote) || match_done;
    end else if (i == 1) begin : g_second
      assign from_left[i] = fwd[i-1];
      assign seed[i]      = !any_hit && quote;
    end else begin : g_rest
      assign from_left[i] = fwd[i-1];
      assign seed[i]      = 1'b0;
    end

    jsfe_match_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .init_val  (i == 0),
      .load_val  (i == 1),
      .seed      (seed[i]),
      .from_left (from_left[i]),
      .data      (data),
      .ch        (pat_char(pat_sel, CELL_IDX_W'(i))),
      .is_last   (CELL_IDX_W'(i) == last_idx),
      .act       (act[i]),
      .fwd       (fwd[i]),
      .done      (done[i])
    );
  end

  `ASSERT_ALWAYS(a_single_position, $onehot(act), "matcher position is not one-hot")

endmodule

>>> rtl/jsfe_out_fifo.sv
// ----------------------------------------------------------------------------
// jsfe_out_fifo
// Small result queue taking up to two words a cycle; gives one unless stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsfe_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr0_en,
  input  jsfe_pkg::out_word_t wr0_data,
  input  logic                wr1_en,
  input  jsfe_pkg::out_word_t wr1_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output jsfe_pkg::out_word_t out_word
);

  import jsfe_pkg::*;

  out_word_t               entry [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   head;
  logic [FIFO_PTR_W-1:0]   tail;
  logic [FIFO_CNT_W-1:0]   count;
  logic [FIFO_CNT_W-1:0]   count_next;
  logic [FIFO_PTR_W-1:0]   tail_next;
  logic                    pop;

  assign out_valid = (count != '0);
  assign out_word  = entry[head];
  assign pop       = out_valid && !out_stall;
  // Hold off new input unless two words fit
  assign full      = (count > FIFO_CNT_W'(FIFO_DEPTH - 2));

  assign tail_next  = tail + FIFO_PTR_W'(1);
  assign count_next = count + FIFO_CNT_W'(wr0_en) + FIFO_CNT_W'(wr1_en) - FIFO_CNT_W'(pop);

  // Store incoming words
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      entry[tail] <= wr0_data;
    end
    if (wr1_en) begin
      entry[tail_next] <= wr1_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + FIFO_PTR_W'(1);
      end
      tail  <= tail + FIFO_PTR_W'(wr0_en) + FIFO_PTR_W'(wr1_en);
      count <= count_next;
    end
  end

  `ASSERT_ALWAYS(a_fill_bound, count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `ASSERT_IMPLIES(a_second_needs_first, wr1_en, wr0_en, "second word written without first")
  `ASSERT_IMPLIES(a_no_write_when_full, wr0_en, !full, "result written while queue full")

endmodule

>>> rtl/json_string_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// json_string_field_extractor_unit
// Streams frame text one byte per word, finds the "response" key (or the
// "content" key after a "message" anchor) and emits the string value bytes,
// then one status word per frame.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------
//   cfg     | in        | cfg_we             | cfg_index, cfg_data
//   in      | in        | in_valid, in_stall | in_word (frame_byte, frame_end)
//   out     | out       | out_valid, out_stall | out_word (kind .. last_result)
//
// One input word per cycle unless stalled; each nonzero byte steps the phase
// logic and the matcher rows in use in the same cycle. A result word appears
// at the earliest in the cycle after its input word, from a four-word queue. A
// frame end that also closes a value byte yields two result words, drained at
// one per cycle unless stalled; in_stall is high while more than two words are
// held. Reset is a single cycle and leaves the block ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_field_extractor_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [jsfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jsfe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  jsfe_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output jsfe_pkg::out_word_t             out_word
);

  import jsfe_pkg::*;

  // Configuration registers
  logic                message_mode;
  logic [CAP_W-1:0]    out_capacity;

  // Frame state
  phase_t              phase;
  phase_t              phase_next;
  logic [CNT_W-1:0]    value_count;
  logic [CNT_W-1:0]    value_count_next;
  logic                pending_backslash;
  logic                pending_backslash_next;
  logic [1:0]          final_status;
  logic [1:0]          final_status_next;

  logic                accept;
  logic                live;
  logic                nonzero;
  logic [DATA_W-1:0]   b;
  logic                fe;
  logic [CAPE_W-1:0]   cap_eff;
  logic                anchor_done;
  logic                key_done;
  logic                key_load;
  cell_ctl_t           anchor_ctl;
  cell_ctl_t           key_ctl;
  pat_sel_t            key_sel;
  logic                emit_byte;
  logic [DATA_W-1:0]   emit_val;
  logic                emit_status;
  logic [1:0]          status_val;
  out_word_t           byte_word;
  out_word_t           status_word;
  logic                fifo_full;

  assign b        = in_word.frame_byte;
  assign fe       = in_word.frame_end;
  assign in_stall = fifo_full;
  assign accept   = in_valid && !in_stall;
  assign live     = accept && (phase != PH_DONE);
  assign nonzero  = (b != CH_NUL);

  assign cap_eff = (32'(out_capacity) > 32'(MAX_CAPACITY)) ? CAPE_W'(MAX_CAPACITY)
                                                           : CAPE_W'(out_capacity);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      message_mode <= 1'b0;
      out_capacity <= CAP_W'(256);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MESSAGE_MODE: message_mode <= cfg_data[0];
        CFG_OUT_CAPACITY: out_capacity <= CAP_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Drive the matcher rows
  assign key_sel = (phase == PH_CKEY) ? PAT_CONTENT : PAT_RESPONSE;

  always_comb begin
    anchor_ctl.clear = accept && fe;
    anchor_ctl.load  = 1'b0;
    anchor_ctl.step  = live && nonzero && (phase == PH_SEARCH) && message_mode;
    key_ctl.clear    = accept && fe;
    key_ctl.load     = key_load;
    key_ctl.step     = live && nonzero &&
                       (((phase == PH_SEARCH) && !message_mode) || (phase == PH_CKEY));
  end

  jsfe_matcher u_anchor (
    .clk        (clk),
    .rst        (rst),
    .ctl        (anchor_ctl),
    .pat_sel    (PAT_ANCHOR),
    .data       (b),
    .match_done (anchor_done)
  );

  jsfe_matcher u_key (
    .clk        (clk),
    .rst        (rst),
    .ctl        (key_ctl),
    .pat_sel    (key_sel),
    .data       (b),
    .match_done (key_done)
  );

  // Advance the phase, copy value bytes and close the frame
  always_comb begin
    phase_t           ph;
    logic             pb;
    logic [1:0]       fs;
    logic             copy_req;
    logic             ovf;

    ph        = phase;
    pb        = pending_backslash;
    fs        = final_status;
    copy_req  = 1'b0;
    emit_val  = b;
    key_load  = 1'b0;
    emit_byte = 1'b0;
    value_count_next = value_count;

    // Byte handling
    if (live && nonzero) begin
      case (phase)
        PH_SEARCH: begin
          if (message_mode) begin
            if (anchor_done) begin
              ph       = PH_CKEY;
              key_load = 1'b1;
            end
          end else if (key_done) begin
            ph = PH_COLON;
          end
        end
        PH_CKEY: begin
          if (key_done) ph = PH_COLON;
        end
        PH_COLON: begin
          if (b == CH_COLON) ph = PH_SPACE;
        end
        PH_SPACE: begin
          if (b == CH_QUOTE) begin
            ph = PH_VALUE;
          end else if (!is_ws(b)) begin
            ph = PH_DONE;
            fs = ST_NONE;
          end
        end
        PH_VALUE: begin
          if (pb) begin
            pb = 1'b0;
            ph = PH_DONE;
            fs = ST_NONE;
          end else if (b == CH_BSLASH) begin
            pb = 1'b1;
          end else if (b == CH_QUOTE) begin
            ph = PH_DONE;
            fs = ST_EXTRACTED;
          end else begin
            copy_req = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // End of text: flush a trailing backslash, then settle the status
    if (live && (!nonzero || fe)) begin
      if (ph == PH_VALUE) begin
        if (pb) begin
          pb       = 1'b0;
          copy_req = 1'b1;
          emit_val = CH_BSLASH;
        end
        ph = PH_DONE;
        fs = ST_EXTRACTED;
      end else if (ph != PH_DONE) begin
        ph = PH_DONE;
        fs = ST_NONE;
      end
    end

    // Copy one byte unless it would reach capacity
    ovf = copy_req && (({1'b0, value_count} + CAPE_W'(1)) >= cap_eff);
    if (copy_req) begin
      if (ovf) begin
        ph = PH_DONE;
        fs = ST_OVERFLOW;
      end else begin
        emit_byte        = 1'b1;
        value_count_next = value_count + CNT_W'(1);
      end
    end

    emit_status = accept && fe;
    status_val  = (ph == PH_DONE) ? fs : ST_NONE;

    // Restart the frame after its status word
    if (accept && fe) begin
      phase_next             = PH_SEARCH;
      pending_backslash_next = 1'b0;
      final_status_next      = ST_NONE;
    end else begin
      phase_next             = ph;
      pending_backslash_next = pb;
      final_status_next      = fs;
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SEARCH;
      value_count       <= '0;
      pending_backslash <= 1'b0;
      final_status      <= ST_NONE;
    end else begin
      phase             <= phase_next;
      value_count       <= (accept && fe) ? '0 : value_count_next;
      pending_backslash <= pending_backslash_next;
      final_status      <= final_status_next;
    end
  end

  // Assemble result words
  always_comb begin
    byte_word.kind         = KIND_VALUE;
    byte_word.value_byte   = emit_val;
    byte_word.status       = ST_NONE;
    byte_word.token_length = '0;
    byte_word.last_result  = 1'b0;

    status_word.kind         = KIND_STATUS;
    status_word.value_byte   = CH_NUL;
    status_word.status       = status_val;
    status_word.token_length = (status_val == ST_EXTRACTED) ? LEN_W'(value_count_next) : '0;
    status_word.last_result  = 1'b1;
  end

  jsfe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr0_en    (emit_byte || emit_status),
    .wr0_data  (emit_byte ? byte_word : status_word),
    .wr1_en    (emit_byte && emit_status),
    .wr1_data  (status_word),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  `ASSERT_IMPLIES(a_bslash_in_value, pending_backslash, phase == PH_VALUE, "stray backslash")

endmodule
